// ----- hdl/slow_start_exit_detector_core_defines.svh -----
// Assertion macros for the slow-start exit detector.
// Used by slow_start_exit_detector_core; no other dependencies.
`ifndef SLOW_START_EXIT_DETECTOR_CORE_DEFINES_SVH
`define SLOW_START_EXIT_DETECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define SSED_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define SSED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSED_ASSERT_ALWAYS(lbl, cond, msg)
`define SSED_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/ssed_pkg.sv -----
// Shared types and constants of the slow-start exit detector.
// Used by slow_start_exit_detector_core; depends on nothing.
`default_nettype none

package ssed_pkg;

	// Default widths of the sequence and RTT datapaths
	localparam int SEQ_BITS_DEF = 64;
	localparam int RTT_BITS_DEF = 32;

	// Event codes
	localparam logic [1:0] EV_SENT    = 2'd0;
	localparam logic [1:0] EV_ACK     = 2'd1;
	localparam logic [1:0] EV_DISABLE = 2'd2;

	// Phase codes
	localparam logic [1:0] PHASE_STD = 2'd0;
	localparam logic [1:0] PHASE_CSS = 2'd1;
	localparam logic [1:0] PHASE_CA  = 2'd2;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 20;
	localparam int CFG_THR_BITS  = 20;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DATAGRAM = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SAMPLES  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CSS_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH_FLOOR = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH_CEIL  = 3'd5;

	// Register reset values
	localparam logic [15:0]             RST_MAX_DATAGRAM = 16'd1200;
	localparam logic                    RST_ENABLE       = 1'b1;
	localparam logic [7:0]              RST_MIN_SAMPLES  = 8'd8;
	localparam logic [7:0]              RST_CSS_LIMIT    = 8'd5;
	localparam logic [CFG_THR_BITS-1:0] RST_THRESH_FLOOR = 20'd4000;
	localparam logic [CFG_THR_BITS-1:0] RST_THRESH_CEIL  = 20'd16000;

	// Growth cap of 8 datagrams, divide by 4; RTT threshold is min RTT / 8
	localparam int ACK_LIMIT_SHIFT = 3;
	localparam int GROWTH_SHIFT    = 2;
	localparam int RTT_DIV_SHIFT   = 3;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic        elicits_ack;
		logic        app_bound;
		logic [63:0] packet_sequence;
		logic        last_in_batch;
		logic        rtt_valid;
		logic [31:0] latest_rtt_us;
		logic [31:0] acked_bytes;
	} in_item_t;

	typedef struct packed {
		logic [63:0] assigned_sequence;
		logic [31:0] window_growth;
		logic [1:0]  phase;
		logic        exit_slow_start;
		logic        in_conservative;
	} out_item_t;

endpackage

`default_nettype wire

// ----- hdl/slow_start_exit_detector_core.sv -----
// Slow-start exit detector: round tracking, mode decisions and growth limit.
// Depends on ssed_pkg and slow_start_exit_detector_core_defines.svh.
//
// The block takes one event per clock cycle, unless in_stall holds it off,
// and returns one result per event. An accepted event sits in an input
// register while the round state is updated by a single pass of compare/add
// logic; the result lands in an output register on the same edge as the state
// update; with the output not stalled, the throughput is one event per cycle.
// The longest path is the RTT threshold add followed by the round-close
// compares on the SEQ_BITS-wide sequence registers. A stalled output holds its
// result while the input register keeps the next event. The configuration
// port is always ready; write it only while no events are in flight.
`default_nettype none
`include "slow_start_exit_detector_core_defines.svh"

module slow_start_exit_detector_core
	import ssed_pkg::*;
#(
	parameter int SEQ_BITS = SEQ_BITS_DEF,
	parameter int RTT_BITS = RTT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire in_item_t                 in_data,
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      out_item_t                out_data,
	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	// RTT width as carried by the 32-bit sample field
	localparam int RW = (RTT_BITS < 32) ? RTT_BITS : 32;
	// Width of the threshold sum
	localparam int TW = ((RW > CFG_THR_BITS) ? RW : CFG_THR_BITS) + 1;

	// Configuration registers
	logic [15:0]             cfg_mds_q;
	logic                    cfg_en_q;
	logic [7:0]              cfg_min_samples_q;
	logic [7:0]              cfg_css_limit_q;
	logic [CFG_THR_BITS-1:0] cfg_floor_q;
	logic [CFG_THR_BITS-1:0] cfg_ceil_q;

	// Pipeline registers
	logic      s1_valid;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      adv;

	// Detector state
	logic [SEQ_BITS-1:0] next_seq_q, latest_sent_q, batch_max_q, round_end_q, entry_end_q;
	logic                ls_valid_q, batch_valid_q, re_valid_q, entry_valid_q;
	logic [RW-1:0]       round_min_q, prev_min_q, base_rtt_q;
	logic                rmin_valid_q, prev_valid_q, base_valid_q;
	logic [7:0]          sample_cnt_q, css_cnt_q;
	logic [1:0]          phase_q;
	logic                exit_q, disabled_q;

	// Next-state values
	logic [SEQ_BITS-1:0] n_next_seq, n_latest_sent, n_batch_max, n_round_end, n_entry_end;
	logic                n_ls_valid, n_batch_valid, n_re_valid, n_entry_valid;
	logic [RW-1:0]       n_round_min, n_prev_min, n_base_rtt;
	logic                n_rmin_valid, n_prev_valid, n_base_valid;
	logic [7:0]          n_sample_cnt, n_css_cnt;
	logic [1:0]          n_phase;
	logic                n_exit, n_disabled;

	// Working values of the update
	logic [SEQ_BITS-1:0] seq, assigned, done_seq;
	logic [RW-1:0]       rtt;
	logic                enabled, enough, qualify, do_close;
	logic [TW-1:0]       th, th_sum;
	logic [31:0]         lim, growth, capped;

	// Hold configuration writes; the port never backs up
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mds_q         <= RST_MAX_DATAGRAM;
			cfg_en_q          <= RST_ENABLE;
			cfg_min_samples_q <= RST_MIN_SAMPLES;
			cfg_css_limit_q   <= RST_CSS_LIMIT;
			cfg_floor_q       <= RST_THRESH_FLOOR;
			cfg_ceil_q        <= RST_THRESH_CEIL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_DATAGRAM: cfg_mds_q         <= cfg_data[15:0];
				CFG_ENABLE:       cfg_en_q          <= cfg_data[0];
				CFG_MIN_SAMPLES:  cfg_min_samples_q <= cfg_data[7:0];
				CFG_CSS_LIMIT:    cfg_css_limit_q   <= cfg_data[7:0];
				CFG_THRESH_FLOOR: cfg_floor_q       <= cfg_data[CFG_THR_BITS-1:0];
				CFG_THRESH_CEIL:  cfg_ceil_q        <= cfg_data[CFG_THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Advance the input register whenever the output register can take a result
	assign adv      = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Decode the transaction and compute the next detector state
	always_comb begin
		n_next_seq    = next_seq_q;
		n_latest_sent = latest_sent_q;
		n_ls_valid    = ls_valid_q;
		n_batch_max   = batch_max_q;
		n_batch_valid = batch_valid_q;
		n_round_end   = round_end_q;
		n_re_valid    = re_valid_q;
		n_entry_end   = entry_end_q;
		n_entry_valid = entry_valid_q;
		n_round_min   = round_min_q;
		n_rmin_valid  = rmin_valid_q;
		n_prev_min    = prev_min_q;
		n_prev_valid  = prev_valid_q;
		n_base_rtt    = base_rtt_q;
		n_base_valid  = base_valid_q;
		n_sample_cnt  = sample_cnt_q;
		n_css_cnt     = css_cnt_q;
		n_phase       = phase_q;
		n_exit        = exit_q;
		n_disabled    = disabled_q;

		seq      = item_s1.packet_sequence[SEQ_BITS-1:0];
		rtt      = item_s1.latest_rtt_us[RW-1:0];
		enabled  = cfg_en_q && !disabled_q;
		qualify  = item_s1.elicits_ack && !item_s1.app_bound && (seq != '0);
		assigned = '0;
		done_seq = '0;
		enough   = 1'b0;
		do_close = 1'b0;
		growth   = '0;

		// Rise threshold: previous minimum / 8, clamped to ceiling then floor
		th = TW'(prev_min_q >> RTT_DIV_SHIFT);
		if (th > TW'(cfg_ceil_q)) begin
			th = TW'(cfg_ceil_q);
		end
		if (th < TW'(cfg_floor_q)) begin
			th = TW'(cfg_floor_q);
		end
		th_sum = TW'(prev_min_q) + th;

		// Conservative growth limit
		lim    = 32'(cfg_mds_q) << ACK_LIMIT_SHIFT;
		capped = (item_s1.acked_bytes > lim) ? lim : item_s1.acked_bytes;

		unique case (item_s1.mode)
			EV_SENT: begin
				// Number ack-eliciting packets
				if (item_s1.elicits_ack) begin
					assigned   = next_seq_q;
					n_next_seq = next_seq_q + SEQ_BITS'(1);
					if (!ls_valid_q || (next_seq_q > latest_sent_q)) begin
						n_latest_sent = next_seq_q;
					end
					n_ls_valid = 1'b1;
				end
			end
			EV_ACK: begin
				// Fold the largest qualifying sequence of the batch
				if (qualify) begin
					if (!batch_valid_q || (seq > batch_max_q)) begin
						n_batch_max = seq;
					end
					n_batch_valid = 1'b1;
				end
				if (item_s1.last_in_batch) begin
					if (enabled && item_s1.rtt_valid && n_batch_valid) begin
						// Open a round if none is running
						if (!re_valid_q) begin
							n_round_end = (ls_valid_q && (latest_sent_q > n_batch_max)) ?
								latest_sent_q : n_batch_max;
							n_re_valid = 1'b1;
						end
						// Update the round minimum and sample count
						if (!rmin_valid_q || (rtt < round_min_q)) begin
							n_round_min = rtt;
						end
						n_rmin_valid = 1'b1;
						if (sample_cnt_q != CNT_MAX) begin
							n_sample_cnt = sample_cnt_q + 8'd1;
						end
						enough = (n_sample_cnt >= cfg_min_samples_q);

						// Enter conservative mode on an RTT rise
						if (phase_q == PHASE_STD) begin
							if (enough && prev_valid_q && (TW'(n_round_min) >= th_sum)) begin
								n_phase       = PHASE_CSS;
								n_base_rtt    = n_round_min;
								n_base_valid  = 1'b1;
								n_entry_end   = n_round_end;
								n_entry_valid = n_re_valid;
								n_css_cnt     = 8'd1;
							end
						end
						// Resume standard mode on an RTT drop
						if (phase_q == PHASE_CSS) begin
							if (enough && base_valid_q && (n_round_min < base_rtt_q)) begin
								n_phase       = PHASE_STD;
								n_base_rtt    = '0;
								n_base_valid  = 1'b0;
								n_entry_end   = '0;
								n_entry_valid = 1'b0;
								n_css_cnt     = '0;
							end
						end

						// Close the round once the batch reaches its end
						do_close = ((phase_q == PHASE_STD) || (phase_q == PHASE_CSS)) &&
							n_re_valid && (n_batch_max >= n_round_end);
						if (do_close) begin
							done_seq     = n_round_end;
							n_prev_min   = n_round_min;
							n_prev_valid = n_rmin_valid;
							n_round_min  = '0;
							n_rmin_valid = 1'b0;
							n_sample_cnt = '0;
							if (ls_valid_q && (latest_sent_q > done_seq)) begin
								n_round_end = latest_sent_q;
							end else begin
								n_round_end = '0;
								n_re_valid  = 1'b0;
							end
							// Count conservative rounds, skipping the entry round
							if (n_phase == PHASE_CSS) begin
								if (n_entry_valid && (n_entry_end == done_seq)) begin
									n_entry_valid = 1'b0;
									n_entry_end   = '0;
								end else begin
									if (n_css_cnt != CNT_MAX) begin
										n_css_cnt = n_css_cnt + 8'd1;
									end
									if (n_css_cnt >= cfg_css_limit_q) begin
										n_phase = PHASE_CA;
										n_exit  = 1'b1;
									end
								end
							end
						end
					end
					n_batch_max   = '0;
					n_batch_valid = 1'b0;
				end
				// Growth under the mode in force after the update
				growth = (enabled && (n_phase == PHASE_CSS)) ?
					(capped >> GROWTH_SHIFT) : item_s1.acked_bytes;
			end
			EV_DISABLE: begin
				// Drop the mode; round tracking is kept
				n_disabled    = 1'b1;
				n_phase       = PHASE_STD;
				n_exit        = 1'b0;
				n_entry_end   = '0;
				n_entry_valid = 1'b0;
				n_base_rtt    = '0;
				n_base_valid  = 1'b0;
				n_css_cnt     = '0;
			end
			default: ;
		endcase
	end

	// Commit the state update with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q    <= SEQ_BITS'(1);
			latest_sent_q <= '0;
			ls_valid_q    <= 1'b0;
			batch_max_q   <= '0;
			batch_valid_q <= 1'b0;
			round_end_q   <= '0;
			re_valid_q    <= 1'b0;
			entry_end_q   <= '0;
			entry_valid_q <= 1'b0;
			round_min_q   <= '0;
			rmin_valid_q  <= 1'b0;
			prev_min_q    <= '0;
			prev_valid_q  <= 1'b0;
			base_rtt_q    <= '0;
			base_valid_q  <= 1'b0;
			sample_cnt_q  <= '0;
			css_cnt_q     <= '0;
			phase_q       <= PHASE_STD;
			exit_q        <= 1'b0;
			disabled_q    <= 1'b0;
		end else if (adv) begin
			next_seq_q    <= n_next_seq;
			latest_sent_q <= n_latest_sent;
			ls_valid_q    <= n_ls_valid;
			batch_max_q   <= n_batch_max;
			batch_valid_q <= n_batch_valid;
			round_end_q   <= n_round_end;
			re_valid_q    <= n_re_valid;
			entry_end_q   <= n_entry_end;
			entry_valid_q <= n_entry_valid;
			round_min_q   <= n_round_min;
			rmin_valid_q  <= n_rmin_valid;
			prev_min_q    <= n_prev_min;
			prev_valid_q  <= n_prev_valid;
			base_rtt_q    <= n_base_rtt;
			base_valid_q  <= n_base_valid;
			sample_cnt_q  <= n_sample_cnt;
			css_cnt_q     <= n_css_cnt;
			phase_q       <= n_phase;
			exit_q        <= n_exit;
			disabled_q    <= n_disabled;
		end
	end

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.assigned_sequence <= 64'(assigned);
			out_q.window_growth     <= growth;
			out_q.phase             <= n_phase;
			out_q.exit_slow_start   <= n_exit;
			out_q.in_conservative   <= cfg_en_q && !n_disabled && (n_phase == PHASE_CSS);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Exit flag is set exactly while in congestion avoidance
	`SSED_ASSERT_ALWAYS(a_exit_phase, exit_q == (phase_q == PHASE_CA), "exit flag mismatch")
	// No conservative round count survives in standard mode
	`SSED_ASSERT_ALWAYS(a_std_count, phase_q != PHASE_STD || css_cnt_q == '0, "stray round count")
	// Baseline exists exactly outside standard mode
	`SSED_ASSERT_ALWAYS(a_baseline, base_valid_q == (phase_q != PHASE_STD), "baseline mismatch")
	// A held input transaction is not lost while the output is stalled
	`SSED_ASSERT_NEXT(a_hold_s1, in_stall, s1_valid, "held transaction lost")

endmodule

`default_nettype wire

// ----- tb/sv/ssed_event_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the slow-start exit detector: predicts every event's result
// from its own copy of the round state and compares it with the block's output.
// Depends on ssed_pkg for the payload types, event, phase and register codes.
module ssed_event_checker
	import ssed_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire in_item_t                 in_data,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire out_item_t                out_data,
	input  wire logic                     cfg_valid,
	input  wire logic                     cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                            mismatch_count,
	output int                            results_pending
);

	localparam int          REPORT_LIMIT   = 10;
	localparam logic [63:0] ACK_LIMIT_PKTS = 64'd8;
	localparam logic [63:0] GROWTH_DIV     = 64'd4;
	localparam logic [31:0] RTT_DIV        = 32'd8;
	localparam logic [7:0]  COUNT_TOP      = 8'hFF;

	// Register copy
	logic [15:0] max_dgram;
	logic        hy_enable;
	logic [7:0]  samples_needed;
	logic [7:0]  css_limit;
	logic [19:0] floor_us;
	logic [19:0] ceil_us;

	// Round and mode state
	logic [63:0] next_seq, last_sent_seq, batch_top, round_end_seq, entry_end_seq;
	logic        last_sent_ok, batch_ok, round_end_ok, entry_ok;
	logic [31:0] round_min, prev_min, baseline;
	logic        round_min_ok, prev_min_ok, baseline_ok;
	logic [7:0]  sample_cnt, css_rounds;
	logic [1:0]  phase_now;
	logic        exit_now, disabled_now;

	out_item_t expected_results[$];
	int        errors;

	function automatic void reset_model();
		max_dgram      = RST_MAX_DATAGRAM;
		hy_enable      = RST_ENABLE;
		samples_needed = RST_MIN_SAMPLES;
		css_limit      = RST_CSS_LIMIT;
		floor_us       = RST_THRESH_FLOOR;
		ceil_us        = RST_THRESH_CEIL;
		next_seq       = 64'd1;
		last_sent_seq  = '0;
		batch_top      = '0;
		round_end_seq  = '0;
		entry_end_seq  = '0;
		last_sent_ok   = 1'b0;
		batch_ok       = 1'b0;
		round_end_ok   = 1'b0;
		entry_ok       = 1'b0;
		round_min      = '0;
		prev_min       = '0;
		baseline       = '0;
		round_min_ok   = 1'b0;
		prev_min_ok    = 1'b0;
		baseline_ok    = 1'b0;
		sample_cnt     = '0;
		css_rounds     = '0;
		phase_now      = PHASE_STD;
		exit_now       = 1'b0;
		disabled_now   = 1'b0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			CFG_MAX_DATAGRAM: max_dgram = val[15:0];
			CFG_ENABLE:       hy_enable = val[0];
			CFG_MIN_SAMPLES:  samples_needed = val[7:0];
			CFG_CSS_LIMIT:    css_limit = val[7:0];
			CFG_THRESH_FLOOR: floor_us = val[19:0];
			CFG_THRESH_CEIL:  ceil_us = val[19:0];
			default: ;
		endcase
	endfunction

	function automatic logic detector_on();
		return hy_enable && !disabled_now;
	endfunction

	// Conservative mode caps the growth at eight datagrams and takes a quarter
	function automatic logic [31:0] allowed_growth(input logic [31:0] bytes);
		logic [63:0] cap;
		logic [63:0] amount;
		if (!detector_on() || phase_now != PHASE_CSS)
			return bytes;
		cap = 64'(max_dgram) * ACK_LIMIT_PKTS;
		amount = 64'(bytes);
		if (amount > cap)
			amount = cap;
		return 32'(amount / GROWTH_DIV);
	endfunction

	// Close the current round once the acked sequence reaches its end
	function automatic void end_round(input logic [63:0] seq);
		logic [63:0] closed;
		if (!round_end_ok || seq < round_end_seq)
			return;
		closed = round_end_seq;
		prev_min = round_min;
		prev_min_ok = round_min_ok;
		round_min = '0;
		round_min_ok = 1'b0;
		sample_cnt = '0;
		if (last_sent_ok && last_sent_seq > closed) begin
			round_end_seq = last_sent_seq;
		end else begin
			round_end_seq = '0;
			round_end_ok = 1'b0;
		end
		if (phase_now != PHASE_CSS)
			return;
		// the round in which conservative mode began does not count
		if (entry_ok && entry_end_seq == closed) begin
			entry_ok = 1'b0;
			entry_end_seq = '0;
			return;
		end
		if (css_rounds != COUNT_TOP)
			css_rounds++;
		if (css_rounds >= css_limit) begin
			phase_now = PHASE_CA;
			exit_now = 1'b1;
		end
	endfunction

	// Fold one RTT sample at the end of a batch and take the mode decisions
	function automatic void fold_batch(input logic [63:0] seq, input logic [31:0] rtt);
		logic        enough;
		logic [63:0] thresh;
		if (!round_end_ok) begin
			round_end_seq = (last_sent_ok && last_sent_seq > seq) ? last_sent_seq : seq;
			round_end_ok = 1'b1;
		end
		if (!round_min_ok || rtt < round_min)
			round_min = rtt;
		round_min_ok = 1'b1;
		if (sample_cnt != COUNT_TOP)
			sample_cnt++;
		enough = sample_cnt >= samples_needed;
		case (phase_now)
			PHASE_STD: begin
				if (enough && prev_min_ok) begin
					// clamp the rise threshold; the floor wins over the ceiling
					thresh = 64'(prev_min / RTT_DIV);
					if (thresh > 64'(ceil_us))
						thresh = 64'(ceil_us);
					if (thresh < 64'(floor_us))
						thresh = 64'(floor_us);
					if (64'(round_min) >= 64'(prev_min) + thresh) begin
						phase_now = PHASE_CSS;
						baseline = round_min;
						baseline_ok = 1'b1;
						entry_end_seq = round_end_seq;
						entry_ok = round_end_ok;
						css_rounds = 8'd1;
					end
				end
				end_round(seq);
			end
			PHASE_CSS: begin
				if (enough && baseline_ok && round_min < baseline) begin
					phase_now = PHASE_STD;
					baseline = '0;
					baseline_ok = 1'b0;
					entry_end_seq = '0;
					entry_ok = 1'b0;
					css_rounds = '0;
				end
				end_round(seq);
			end
			default: ;
		endcase
	endfunction

	function automatic out_item_t predict_event(input in_item_t ev);
		out_item_t res;
		res = '0;
		case (ev.mode)
			EV_SENT: begin
				if (ev.elicits_ack) begin
					res.assigned_sequence = next_seq;
					next_seq = next_seq + 64'd1;
					if (!last_sent_ok || res.assigned_sequence > last_sent_seq)
						last_sent_seq = res.assigned_sequence;
					last_sent_ok = 1'b1;
				end
			end
			EV_ACK: begin
				if (ev.elicits_ack && !ev.app_bound && ev.packet_sequence != '0) begin
					if (!batch_ok || ev.packet_sequence > batch_top)
						batch_top = ev.packet_sequence;
					batch_ok = 1'b1;
				end
				if (ev.last_in_batch) begin
					if (detector_on() && ev.rtt_valid && batch_ok)
						fold_batch(batch_top, ev.latest_rtt_us);
					batch_top = '0;
					batch_ok = 1'b0;
				end
				res.window_growth = allowed_growth(ev.acked_bytes);
			end
			EV_DISABLE: begin
				disabled_now = 1'b1;
				phase_now = PHASE_STD;
				exit_now = 1'b0;
				entry_end_seq = '0;
				entry_ok = 1'b0;
				baseline = '0;
				baseline_ok = 1'b0;
				css_rounds = '0;
			end
			default: ;
		endcase
		res.phase = phase_now;
		res.exit_slow_start = exit_now;
		res.in_conservative = detector_on() && phase_now == PHASE_CSS;
		return res;
	endfunction

	// Compare outputs first, then record register writes and new events
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			reset_model();
			expected_results.delete();
			errors = 0;
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: unexpected result seq %0h growth %0d phase %0d exit %0b css %0b",
							$realtime, out_data.assigned_sequence, out_data.window_growth,
							out_data.phase, out_data.exit_slow_start, out_data.in_conservative);
				end else begin
					want = expected_results.pop_front();
					if (want !== out_data) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("%0t: mismatch, expected seq %0h growth %0d phase %0d exit %0b css %0b",
								$realtime, want.assigned_sequence, want.window_growth, want.phase,
								want.exit_slow_start, want.in_conservative);
							$display("%0t:            actual seq %0h growth %0d phase %0d exit %0b css %0b",
								$realtime, out_data.assigned_sequence, out_data.window_growth,
								out_data.phase, out_data.exit_slow_start, out_data.in_conservative);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				expected_results.push_back(predict_event(in_data));
			mismatch_count <= errors;
			results_pending <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/slow_start_exit_detector_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the slow-start exit detector testbench: clock, reset, event traffic,
// register settings and the verdict. Depends on ssed_pkg and ssed_event_checker.
module slow_start_exit_detector_core_tb;
	import ssed_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          PHASE_ITEMS = 170;
	localparam logic [1:0]  EV_UNUSED   = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatch_count;
	int                       results_pending;

	int          cycle_count = 0;
	int          hold_requests;
	int          burst_left;
	int          burst_max;
	int          gap_max;
	int          items_accepted;
	logic [63:0] sent_total;
	logic [63:0] ack_next;
	int unsigned rtt_level;
	int unsigned floor_setting;

	slow_start_exit_detector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ssed_event_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stall on a changing pattern, hold off for a long stretch on request
	initial begin : receiver
		int pattern;
		int span;
		int seen;
		int hold_left;
		seen = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			pattern = $urandom_range(0, 4);
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(posedge clk);
				if (hold_left > 0) begin
					out_stall <= 1'b1;
					hold_left--;
				end else if (hold_requests != seen) begin
					seen = hold_requests;
					hold_left = HOLD_CYCLES;
					out_stall <= 1'b1;
				end else begin
					case (pattern)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 1) == 0);
						3: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ~out_stall;
					endcase
				end
			end
		end
	end

	// Offer one event and hold it until accepted; idle between bursts
	task automatic send_event(input in_item_t ev);
		int gap;
		in_data <= ev;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_accepted++;
		if (ev.mode == EV_SENT && ev.elicits_ack)
			sent_total++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and hold until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_settings(input logic [15:0] dgram, input logic enable,
			input logic [7:0] samples, input logic [7:0] limit,
			input logic [19:0] lo, input logic [19:0] hi);
		cfg_write(CFG_MAX_DATAGRAM, 20'(dgram));
		cfg_write(CFG_ENABLE, 20'(enable));
		cfg_write(CFG_MIN_SAMPLES, 20'(samples));
		cfg_write(CFG_CSS_LIMIT, 20'(limit));
		cfg_write(CFG_THRESH_FLOOR, lo);
		cfg_write(CFG_THRESH_CEIL, hi);
		cfg_valid <= 1'b0;
		floor_setting = 32'(lo);
	endtask

	function automatic in_item_t sent_item(input logic elicit);
		in_item_t ev;
		ev = '0;
		ev.mode = EV_SENT;
		ev.elicits_ack = elicit;
		return ev;
	endfunction

	function automatic in_item_t ack_item(input logic [63:0] seq, input logic last,
			input logic rtt_ok, input logic [31:0] rtt, input logic [31:0] bytes);
		in_item_t ev;
		ev = '0;
		ev.mode = EV_ACK;
		ev.elicits_ack = 1'b1;
		ev.packet_sequence = seq;
		ev.last_in_batch = last;
		ev.rtt_valid = rtt_ok;
		ev.latest_rtt_us = rtt;
		ev.acked_bytes = bytes;
		return ev;
	endfunction

	function automatic logic [31:0] random_bytes();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(0, 600000);
	endfunction

	// Arbitrary event with every field random; disable only when allowed
	function automatic in_item_t noise_item(input bit disable_ok);
		in_item_t     ev;
		int           pick;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		ev = raw[$bits(in_item_t)-1:0];
		pick = $urandom_range(0, 19);
		if (pick < 8)
			ev.mode = EV_SENT;
		else if (pick < 16)
			ev.mode = EV_ACK;
		else if (pick == 19 && disable_ok)
			ev.mode = EV_DISABLE;
		else
			ev.mode = EV_UNUSED;
		if ($urandom_range(0, 1) == 0)
			ev.latest_rtt_us = rtt_level + $urandom_range(0, 5000);
		if ($urandom_range(0, 1) == 0)
			ev.packet_sequence = ack_next + $urandom_range(0, 4);
		if ($urandom_range(0, 1) == 0)
			ev.acked_bytes = random_bytes();
		return ev;
	endfunction

	// One RTT round: send a flight, move the RTT level, ack the flight in batches
	task automatic flight_round();
		in_item_t    ev;
		int          batch;
		int unsigned step;
		logic [63:0] upper;
		repeat ($urandom_range(3, 10)) send_event(sent_item(1'b1));
		step = (rtt_level / 8 > floor_setting) ? rtt_level / 8 : floor_setting;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: rtt_level = rtt_level + step + $urandom_range(0, 3000);
			4, 5, 6:    rtt_level = rtt_level - rtt_level / 4;
			default: ;
		endcase
		if (rtt_level > 3000000 || rtt_level < 1000)
			rtt_level = $urandom_range(20000, 60000);
		upper = sent_total;
		while (ack_next <= upper) begin
			batch = $urandom_range(1, 3);
			while (batch > 0 && ack_next <= upper) begin
				batch--;
				ev = ack_item(ack_next, batch == 0 || ack_next == upper,
					$urandom_range(0, 9) != 0, rtt_level + $urandom_range(0, 400),
					random_bytes());
				ev.app_bound = ($urandom_range(0, 15) == 0);
				ack_next++;
				send_event(ev);
			end
			// a packet sent in the middle belongs to the next round
			if ($urandom_range(0, 4) == 0)
				send_event(sent_item(1'b1));
		end
	endtask

	task automatic run_traffic(input int quota, input bit disable_ok);
		int target;
		target = items_accepted + quota;
		ack_next = sent_total + 1;
		rtt_level = $urandom_range(20000, 60000);
		while (items_accepted < target) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) send_event(noise_item(disable_ok));
			else
				flight_round();
		end
	endtask

	initial begin : stimulus
		in_item_t ev;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		hold_requests <= 0;
		burst_left = 1;
		burst_max = 8;
		gap_max = 3;
		items_accepted = 0;
		sent_total = '0;
		ack_next = 64'd1;
		rtt_level = 40000;
		floor_setting = 32'(RST_THRESH_FLOOR);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed events under the reset register values
		send_event(sent_item(1'b0));
		send_event(sent_item(1'b1));
		send_event(sent_item(1'b1));
		ev = sent_item(1'b1);
		ev.mode = EV_UNUSED;
		send_event(ev);
		// batch ends that change nothing: no qualifying packet, no RTT sample
		send_event(ack_item(64'd0, 1'b1, 1'b1, 32'd5000, 32'd1000));
		ev = ack_item(64'd1, 1'b1, 1'b1, 32'd5000, 32'd100);
		ev.app_bound = 1'b1;
		send_event(ev);
		ev = ack_item(64'd1, 1'b1, 1'b1, 32'd5000, 32'd100);
		ev.elicits_ack = 1'b0;
		send_event(ev);
		send_event(ack_item(64'd1, 1'b1, 1'b0, 32'd5000, 32'd9600));
		// RTT extremes, byte extremes, then the top sequence closes its own round
		send_event(ack_item(64'd1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0));
		send_event(ack_item(64'd2, 1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF));
		send_event(sent_item(1'b1));
		send_event(ack_item('1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_event(ack_item(64'd3, 1'b1, 1'b1, 32'd30000, 32'd1));
		repeat (6) send_event(noise_item(1'b0));

		// Random traffic under a series of register settings
		drain_results();
		write_settings(16'd1200, 1'b1, 8'd1, 8'd3, 20'd4000, 20'd16000);
		run_traffic(PHASE_ITEMS, 1'b0);

		drain_results();
		write_settings(16'd65535, 1'b1, 8'd2, 8'd1, 20'd0, 20'd0);
		run_traffic(PHASE_ITEMS, 1'b0);

		drain_results();
		write_settings(16'd1200, 1'b0, 8'd1, 8'd2, 20'd4000, 20'd16000);
		run_traffic(PHASE_ITEMS, 1'b0);

		drain_results();
		write_settings(16'd30000, 1'b1, 8'd255, 8'd255, 20'd1000000, 20'd1000000);
		run_traffic(PHASE_ITEMS, 1'b0);

		// floor above ceiling
		drain_results();
		burst_max = 30;
		gap_max = 0;
		write_settings(16'd1500, 1'b1, 8'd3, 8'd4, 20'd20000, 20'd5000);
		run_traffic(PHASE_ITEMS, 1'b0);

		// long receiver hold-off while events keep coming, so the block backs up
		drain_results();
		write_settings(16'd9000, 1'b1, 8'd1, 8'd2, 20'd1000, 20'd1000000);
		hold_requests <= hold_requests + 1;
		run_traffic(PHASE_ITEMS, 1'b0);

		drain_results();
		burst_max = 12;
		gap_max = 6;
		write_settings(16'd1200, 1'b1, 8'd2, 8'd3, 20'd4000, 20'd16000);
		run_traffic(PHASE_ITEMS / 2, 1'b0);
		drain_results();
		run_traffic(PHASE_ITEMS / 2, 1'b0);

		drain_results();
		burst_max = 8;
		gap_max = 2;
		write_settings(16'd65535, 1'b1, 8'd1, 8'd255, 20'd0, 20'd1000000);
		run_traffic(PHASE_ITEMS, 1'b0);

		// disable is permanent until reset, so it only appears in the last phase
		drain_results();
		write_settings(16'd1200, 1'b1, 8'd1, 8'd3, 20'd4000, 20'd16000);
		run_traffic(PHASE_ITEMS / 2, 1'b0);
		ev = sent_item(1'b0);
		ev.mode = EV_DISABLE;
		send_event(ev);
		run_traffic(PHASE_ITEMS / 2, 1'b1);

		drain_results();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
